FILE: rtl/core/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder: word types, decoder state,
// code unit constants and sequence length codes. No dependencies.
`default_nettype none

package u8u16_pkg;

	localparam int MaxUnits = 5;

	localparam logic [15:0] ReplChar = 16'hFFFD;
	localparam logic [15:0] HighSurrBase = 16'hD800;
	localparam logic [15:0] LowSurrBase = 16'hDC00;
	localparam logic [20:0] SurrFirst = 21'h00D800;
	localparam logic [20:0] SurrLast = 21'h00DFFF;
	localparam logic [20:0] SuppFirst = 21'h010000;
	localparam logic [20:0] CodeMax = 21'h10FFFF;
	localparam logic [20:0] Min2Byte = 21'h000080;
	localparam logic [20:0] Min3Byte = 21'h000800;
	localparam logic [20:0] BmpMax = 21'h00FFFF;

	localparam logic [2:0] SeqNone = 3'd0;
	localparam logic [2:0] SeqTwo = 3'd2;
	localparam logic [2:0] SeqThree = 3'd3;
	localparam logic [2:0] SeqFour = 3'd4;

	typedef struct packed {
		logic [7:0] byte_value;
		logic has_byte;
		logic last_byte;
		logic append_nul;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic replaced;
		logic last_of_run;
		logic last_of_string;
	} out_item_t;

	typedef struct packed {
		logic [20:0] partial_code;
		logic [2:0] sequence_length;
		logic [1:0] bytes_held;
	} dec_state_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic replaced;
	} unit_t;

	typedef struct packed {
		unit_t [MaxUnits-1:0] units;
		logic [2:0] count;
		logic end_of_string;
	} unit_set_t;

endpackage

`default_nettype wire

FILE: rtl/core/u8u16_if.sv
// Valid/ready channel interfaces for input bytes and output code units.
// Depends on u8u16_pkg for the word types.
`default_nettype none

interface u8u16_in_if;
	import u8u16_pkg::*;
	logic valid;
	logic ready;
	in_item_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface u8u16_out_if;
	import u8u16_pkg::*;
	logic valid;
	logic ready;
	out_item_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder: input word register, decoder
// state, and a shifting result buffer. Uses u8u16_pkg, u8u16_if, u8u16_decode.
//
// Usage: bytes carries one UTF-8 byte per word with has_byte, last_byte and
// append_nul flags; units carries one UTF-16 code unit per word with its
// replaced, last_of_run and last_of_string flags. Both are valid/ready.
// An accepted byte is held in the input register and decoded from there into
// a list of up to five code units, which is loaded into the result buffer;
// the first unit is offered on units from that buffer.
// Units leave one per cycle while units is ready. A byte that yields one unit
// or none does not hold the input, so such bytes stream at one byte per cycle
// while units is ready; a byte that yields more holds the input while the
// single-unit output port drains them. The next byte is taken while the buffer
// still drains its last unit. When units stalls, the buffer holds its words and
// bytes drops ready once the input register is full. Reset clears the open
// sequence and empties both registers; no partial code point survives reset.
`default_nettype none

module utf8_to_utf16_transcoder_top (
	input wire logic clk,
	input wire logic arst_n,
	u8u16_in_if.sink bytes,
	u8u16_out_if.source units
);
	import u8u16_pkg::*;

	in_item_t item_s1;
	logic valid_s1;
	dec_state_t state_q;
	dec_state_t state_next;
	unit_set_t set_next;
	unit_t [MaxUnits-1:0] units_q;
	logic [2:0] rem_q;
	logic eos_q;
	logic load;
	logic out_fire;

	u8u16_decode u_decode (
		.item(item_s1),
		.state(state_q),
		.result(set_next),
		.next_state(state_next)
	);

	assign out_fire = units.valid && units.ready;
	assign load = valid_s1 && (rem_q == 3'd0 || (rem_q == 3'd1 && units.ready));
	assign bytes.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1 <= bytes.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			rem_q <= 3'd0;
			eos_q <= 1'b0;
		end else if (load) begin
			state_q <= state_next;
			rem_q <= set_next.count;
			eos_q <= set_next.end_of_string;
		end else if (out_fire) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			units_q <= set_next.units;
		end else if (out_fire) begin
			for (int i = 0; i < MaxUnits - 1; i++) begin
				units_q[i] <= units_q[i+1];
			end
		end
	end

	assign units.valid = rem_q != 3'd0;
	assign units.item.code_unit = units_q[0].code_unit;
	assign units.item.replaced = units_q[0].replaced;
	assign units.item.last_of_run = rem_q == 3'd1;
	assign units.item.last_of_string = rem_q == 3'd1 && eos_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'(MaxUnits))
		else $error("result buffer count out of range");

	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.sequence_length == SeqNone |-> state_q.bytes_held == 2'd0)
		else $error("bytes held with no sequence open");

	a_open_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.sequence_length != SeqNone |->
		state_q.bytes_held != 2'd0 && {1'b0, state_q.bytes_held} < state_q.sequence_length)
		else $error("open sequence holds an impossible byte count");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load && item_s1.last_byte |=> state_q == '0)
		else $error("sequence state survives end of string");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !load |=> rem_q == $past(rem_q) - 3'd1)
		else $error("result buffer did not advance by one word");

endmodule

`default_nettype wire

FILE: rtl/core/u8u16_decode.sv
// Combinational decode of one input word against the current sequence state:
// produces the ordered list of code units and the next state. Uses u8u16_pkg.
`default_nettype none

module u8u16_decode (
	input u8u16_pkg::in_item_t item,
	input u8u16_pkg::dec_state_t state,
	output u8u16_pkg::unit_set_t result,
	output u8u16_pkg::dec_state_t next_state
);
	import u8u16_pkg::*;

	always_comb begin
		logic [7:0] b;
		logic open_seq;
		logic is_cont;
		logic fresh_go;
		logic [2:0] held_c;
		logic [20:0] code_c;
		logic [20:0] supp;
		logic complete;
		logic bad;
		logic [2:0] ra;
		logic [1:0] mid_n;
		unit_t mid0;
		unit_t mid1;
		logic [1:0] rd;
		logic [2:0] end_a;
		logic [2:0] end_m;
		logic [2:0] end_d;
		logic [2:0] total;
		logic [2:0] kk;
		logic [2:0] rel;
		dec_state_t st;

		b = item.byte_value;
		st = state;
		ra = 3'd0;
		mid_n = 2'd0;
		mid0 = '{code_unit: ReplChar, replaced: 1'b1};
		mid1 = '{code_unit: ReplChar, replaced: 1'b1};
		rd = 2'd0;
		bad = 1'b0;

		open_seq = item.has_byte && state.sequence_length != SeqNone && state.bytes_held != 2'd0
			&& {1'b0, state.bytes_held} < state.sequence_length;
		is_cont = b[7:6] == 2'b10;
		held_c = {1'b0, state.bytes_held} + 3'd1;
		code_c = {state.partial_code[14:0], b[5:0]};
		complete = held_c >= state.sequence_length;
		supp = code_c - SuppFirst;
		fresh_go = item.has_byte && (!open_seq || !is_cont);

		if (open_seq && !is_cont) begin
			ra = {1'b0, state.bytes_held};
		end

		if (item.has_byte) begin
			st = '0;
		end

		if (open_seq && is_cont) begin
			case (state.sequence_length)
				SeqTwo: bad = code_c < Min2Byte;
				SeqThree: bad = code_c < Min3Byte || (code_c >= SurrFirst && code_c <= SurrLast);
				default: bad = code_c < SuppFirst || code_c > CodeMax;
			endcase
			if (!complete) begin
				st.partial_code = code_c;
				st.sequence_length = state.sequence_length;
				st.bytes_held = held_c[1:0];
			end else if (bad) begin
				ra = state.sequence_length;
			end else if (code_c > BmpMax) begin
				mid_n = 2'd2;
				mid0 = '{code_unit: HighSurrBase + {6'd0, supp[19:10]}, replaced: 1'b0};
				mid1 = '{code_unit: LowSurrBase + {6'd0, supp[9:0]}, replaced: 1'b0};
			end else begin
				mid_n = 2'd1;
				mid0 = '{code_unit: code_c[15:0], replaced: 1'b0};
			end
		end

		if (fresh_go) begin
			if (b[7] == 1'b0) begin
				mid_n = 2'd1;
				mid0 = '{code_unit: {8'd0, b}, replaced: 1'b0};
			end else if (b[7:5] == 3'b110) begin
				st = '{partial_code: {16'd0, b[4:0]}, sequence_length: SeqTwo, bytes_held: 2'd1};
			end else if (b[7:4] == 4'b1110) begin
				st = '{partial_code: {17'd0, b[3:0]}, sequence_length: SeqThree, bytes_held: 2'd1};
			end else if (b[7:3] == 5'b11110) begin
				st = '{partial_code: {18'd0, b[2:0]}, sequence_length: SeqFour, bytes_held: 2'd1};
			end else begin
				mid_n = 2'd1;
			end
		end

		if (item.last_byte) begin
			if (st.sequence_length != SeqNone) begin
				rd = st.bytes_held;
			end
			st = '0;
		end

		end_a = ra;
		end_m = end_a + {1'b0, mid_n};
		end_d = end_m + {1'b0, rd};
		total = end_d + {2'd0, item.last_byte && item.append_nul};

		for (int k = 0; k < MaxUnits; k++) begin
			kk = 3'(k);
			rel = kk - end_a;
			if (kk < end_a || (kk >= end_m && kk < end_d)) begin
				result.units[k] = '{code_unit: ReplChar, replaced: 1'b1};
			end else if (kk < end_m) begin
				result.units[k] = rel[0] ? mid1 : mid0;
			end else begin
				result.units[k] = '{code_unit: 16'h0000, replaced: 1'b0};
			end
		end
		result.count = total;
		result.end_of_string = item.last_byte;
		next_state = st;
	end

endmodule

`default_nettype wire

FILE: sim/tb_utf8_to_utf16_transcoder_top.sv
`timescale 1ns / 1ps
// Testbench for utf8_to_utf16_transcoder_top: feeds UTF-8 strings as byte words
// and checks every UTF-16 code unit against an in-bench decoder.
// Depends on u8u16_pkg, u8u16_if and the transcoder top level.

module tb_utf8_to_utf16_transcoder_top;
	import u8u16_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int MaxWait = 17;
	localparam int HoldCycles = 300;

	logic clk;
	logic arst_n;

	u8u16_in_if bytes_if ();
	u8u16_out_if units_if ();

	utf8_to_utf16_transcoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_if.sink),
		.units(units_if.source)
	);

	in_item_t byte_words[$];
	out_item_t expected_units[$];
	logic [7:0] string_bytes[$];

	logic [20:0] dec_code;
	logic [2:0] dec_len;
	logic [1:0] dec_held;

	int err_count = 0;
	int cycle_count = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic out_item_t make_unit(input logic [15:0] code, input logic rep);
		out_item_t u;
		u.code_unit = code;
		u.replaced = rep;
		u.last_of_run = 1'b0;
		u.last_of_string = 1'b0;
		return u;
	endfunction

	function automatic void decode_word(input in_item_t w);
		out_item_t step_q[$];
		logic [7:0] b;
		logic [20:0] cp;
		logic [20:0] v;
		logic fresh;
		logic bad;
		b = w.byte_value;
		fresh = 1'b0;
		if (w.has_byte) begin
			if (dec_len == SeqNone || dec_held == 2'd0 || {1'b0, dec_held} >= dec_len) begin
				fresh = 1'b1;
			end else if (b[7:6] != 2'b10) begin
				repeat (dec_held) step_q.push_back(make_unit(ReplChar, 1'b1));
				fresh = 1'b1;
			end else begin
				dec_code = {dec_code[14:0], b[5:0]};
				if ({1'b0, dec_held} + 3'd1 < dec_len) begin
					dec_held = dec_held + 2'd1;
				end else begin
					cp = dec_code;
					case (dec_len)
						SeqTwo: bad = cp < Min2Byte;
						SeqThree: bad = cp < Min3Byte || (cp >= SurrFirst && cp <= SurrLast);
						default: bad = cp < SuppFirst || cp > CodeMax;
					endcase
					if (bad) begin
						repeat (dec_len) step_q.push_back(make_unit(ReplChar, 1'b1));
					end else if (cp > BmpMax) begin
						v = cp - SuppFirst;
						step_q.push_back(make_unit(HighSurrBase + {6'b0, v[19:10]}, 1'b0));
						step_q.push_back(make_unit(LowSurrBase + {6'b0, v[9:0]}, 1'b0));
					end else begin
						step_q.push_back(make_unit(cp[15:0], 1'b0));
					end
					dec_code = '0;
					dec_len = SeqNone;
					dec_held = 2'd0;
				end
			end
			if (fresh) begin
				dec_code = '0;
				dec_len = SeqNone;
				dec_held = 2'd0;
				if (!b[7]) begin
					step_q.push_back(make_unit({8'h00, b}, 1'b0));
				end else if (b[7:5] == 3'b110) begin
					dec_len = SeqTwo;
					dec_code = {16'b0, b[4:0]};
					dec_held = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					dec_len = SeqThree;
					dec_code = {17'b0, b[3:0]};
					dec_held = 2'd1;
				end else if (b[7:3] == 5'b11110) begin
					dec_len = SeqFour;
					dec_code = {18'b0, b[2:0]};
					dec_held = 2'd1;
				end else begin
					step_q.push_back(make_unit(ReplChar, 1'b1));
				end
			end
		end
		if (w.last_byte) begin
			if (dec_len != SeqNone)
				repeat (dec_held) step_q.push_back(make_unit(ReplChar, 1'b1));
			dec_code = '0;
			dec_len = SeqNone;
			dec_held = 2'd0;
			if (w.append_nul)
				step_q.push_back(make_unit(16'h0000, 1'b0));
		end
		if (step_q.size() > 0) begin
			step_q[step_q.size() - 1].last_of_run = 1'b1;
			step_q[step_q.size() - 1].last_of_string = w.last_byte;
		end
		foreach (step_q[i]) expected_units.push_back(step_q[i]);
	endfunction

	function automatic void check_unit(input out_item_t got);
		out_item_t want;
		if (expected_units.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("unexpected code unit %h rep=%b run=%b str=%b", got.code_unit,
					got.replaced, got.last_of_run, got.last_of_string);
		end else begin
			want = expected_units.pop_front();
			if (got.code_unit !== want.code_unit || got.replaced !== want.replaced ||
					got.last_of_run !== want.last_of_run ||
					got.last_of_string !== want.last_of_string) begin
				err_count++;
				if (err_count <= 10)
					$display("mismatch: expected %h rep=%b run=%b str=%b, got %h rep=%b run=%b str=%b",
						want.code_unit, want.replaced, want.last_of_run, want.last_of_string,
						got.code_unit, got.replaced, got.last_of_run, got.last_of_string);
			end
		end
	endfunction

	task automatic add_word(input logic [7:0] b, input logic has, input logic last,
			input logic nul);
		in_item_t w;
		w.byte_value = b;
		w.has_byte = has;
		w.last_byte = last;
		w.append_nul = nul;
		byte_words.push_back(w);
	endtask

	task automatic add_code_point();
		logic [20:0] cp;
		logic [7:0] enc [0:3];
		int kind;
		int nbytes;
		int keep;
		kind = $urandom_range(0, 99);
		keep = 0;
		cp = '0;
		if (kind < 30) begin
			nbytes = 1;
			cp = 21'($urandom_range(0, 'h7F));
		end else if (kind < 48) begin
			nbytes = 2;
			cp = 21'($urandom_range('h80, 'h7FF));
		end else if (kind < 66) begin
			nbytes = 3;
			cp = 21'($urandom_range('h800, 'hFFFF));
			if (cp >= SurrFirst && cp <= SurrLast)
				cp = cp ^ 21'h004000;
		end else if (kind < 80) begin
			nbytes = 4;
			cp = 21'($urandom_range('h10000, 'h10FFFF));
		end else if (kind < 85) begin
			nbytes = $urandom_range(2, 4);
			cp = 21'($urandom_range(0, nbytes == 2 ? 'h7F : nbytes == 3 ? 'h7FF : 'hFFFF));
		end else if (kind < 88) begin
			nbytes = 3;
			cp = 21'($urandom_range('hD800, 'hDFFF));
		end else if (kind < 91) begin
			nbytes = 4;
			cp = 21'($urandom_range('h110000, 'h1FFFFF));
		end else if (kind < 95) begin
			nbytes = $urandom_range(2, 4);
			cp = 21'($urandom_range(0, 'h1FFFFF));
			keep = $urandom_range(1, nbytes - 1);
		end else begin
			nbytes = 0;
			string_bytes.push_back(8'($urandom_range(0, 255)));
		end
		case (nbytes)
			1: enc[0] = {1'b0, cp[6:0]};
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			4: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
			default: ;
		endcase
		if (keep == 0)
			keep = nbytes;
		for (int i = 0; i < keep; i++)
			string_bytes.push_back(enc[i]);
	endtask

	// Byte driver: one wait drawn per word, with calm stretches of back-to-back words.
	int send_wait;
	logic send_calm;
	always @(posedge clk or negedge arst_n) begin
		logic sending;
		in_item_t next_word;
		if (!arst_n) begin
			bytes_if.valid <= 1'b0;
			bytes_if.item <= '0;
			send_wait = 0;
			send_calm = 1'b0;
			dec_code = '0;
			dec_len = SeqNone;
			dec_held = 2'd0;
		end else begin
			sending = bytes_if.valid;
			if (bytes_if.valid && bytes_if.ready) begin
				decode_word(bytes_if.item);
				sending = 1'b0;
				send_wait = send_calm ? 0 : $urandom_range(0, MaxWait);
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
			end
			if (!sending) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (byte_words.size() > 0) begin
					next_word = byte_words.pop_front();
					bytes_if.item <= next_word;
					sending = 1'b1;
				end
			end
			bytes_if.valid <= sending;
		end
	end

	// Unit monitor: random stalls per unit, plus two long hold-offs that back up the input.
	int recv_wait;
	int hold_cycles;
	int units_seen;
	logic recv_calm;
	always @(posedge clk or negedge arst_n) begin
		logic ready_next;
		if (!arst_n) begin
			units_if.ready <= 1'b0;
			recv_wait = 0;
			hold_cycles = 0;
			units_seen = 0;
			recv_calm = 1'b0;
		end else begin
			if (units_if.valid && units_if.ready) begin
				check_unit(units_if.item);
				units_seen++;
				if (units_seen == 100 || units_seen == 400)
					hold_cycles = HoldCycles;
				recv_wait = recv_calm ? 0 : $urandom_range(0, MaxWait);
				if ($urandom_range(0, 29) == 0)
					recv_calm = !recv_calm;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				ready_next = 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			units_if.ready <= ready_next;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int word_count;
		int pick;
		int last_idx;
		logic split_end;
		arst_n = 1'b0;
		bytes_if.valid = 1'b0;
		bytes_if.item = '0;
		units_if.ready = 1'b0;

		add_word(8'h00, 1'b1, 1'b0, 1'b1);
		add_word(8'hDF, 1'b1, 1'b0, 1'b0);
		add_word(8'hBF, 1'b1, 1'b0, 1'b0);
		add_word(8'hC1, 1'b1, 1'b0, 1'b0);
		add_word(8'hBF, 1'b1, 1'b0, 1'b0);
		add_word(8'hE0, 1'b1, 1'b0, 1'b0);
		add_word(8'hA0, 1'b1, 1'b0, 1'b0);
		add_word(8'h80, 1'b1, 1'b0, 1'b0);
		add_word(8'hED, 1'b1, 1'b0, 1'b0);
		add_word(8'hA0, 1'b1, 1'b0, 1'b0);
		add_word(8'h80, 1'b1, 1'b0, 1'b0);
		add_word(8'hF4, 1'b1, 1'b0, 1'b0);
		add_word(8'h8F, 1'b1, 1'b0, 1'b0);
		add_word(8'hBF, 1'b1, 1'b0, 1'b0);
		add_word(8'hBF, 1'b1, 1'b0, 1'b0);
		add_word(8'hF5, 1'b1, 1'b0, 1'b0);
		add_word(8'h80, 1'b1, 1'b0, 1'b0);
		add_word(8'h80, 1'b1, 1'b0, 1'b0);
		add_word(8'h80, 1'b1, 1'b0, 1'b0);
		add_word(8'h80, 1'b1, 1'b0, 1'b0);
		add_word(8'hFF, 1'b1, 1'b0, 1'b0);
		add_word(8'hC3, 1'b1, 1'b0, 1'b0);
		add_word(8'h41, 1'b1, 1'b0, 1'b0);
		add_word(8'hF0, 1'b1, 1'b0, 1'b0);
		add_word(8'h90, 1'b1, 1'b1, 1'b1);
		add_word(8'hA5, 1'b0, 1'b0, 1'b1);
		add_word(8'h00, 1'b0, 1'b1, 1'b0);
		add_word(8'h00, 1'b0, 1'b1, 1'b1);

		word_count = byte_words.size();
		while (word_count < 410) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
				word_count++;
			end else if (pick < 8) begin
				add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'($urandom_range(0, 1)));
				word_count++;
			end else begin
				string_bytes.delete();
				repeat ($urandom_range(1, 10)) add_code_point();
				split_end = $urandom_range(0, 9) == 0;
				last_idx = string_bytes.size() - 1;
				foreach (string_bytes[i]) begin
					add_word(string_bytes[i], 1'b1, !split_end && i == last_idx,
						1'($urandom_range(0, 1)));
					word_count++;
				end
				if (split_end) begin
					add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1,
						1'($urandom_range(0, 1)));
					word_count++;
				end
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_words.size() != 0 || bytes_if.valid || expected_units.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0 && expected_units.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
